FILE: sv/assert_macros.svh
// Assertion helpers for the cache datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent implication check, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// Next-cycle implication check
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`endif

FILE: sv/slru_pkg.sv
package slru_pkg;
	// Controller to datapath commands
	typedef struct packed {
		logic start;
		logic scan_step;
		logic op_step;
	} ctl_cmd_t;

	// Datapath status
	typedef struct packed {
		logic scan_done;
		logic op_done;
	} ctl_sts_t;

	localparam logic CMD_PUT = 1'b0;
	localparam logic CMD_GET = 1'b1;
	localparam logic [0:0] REG_SOFT = 1'b0;
	localparam logic [0:0] REG_HARD = 1'b1;
endpackage

FILE: sv/slru_ctrl.sv
// Sequencer: accept a word, scan the table, run the list steps, present the result
module slru_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_fire,
	input  slru_pkg::ctl_sts_t   sts,
	input  logic                 out_taken,
	output slru_pkg::ctl_cmd_t   cmd,
	output logic                 busy,
	output logic                 out_valid
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_OPS  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0] state_q;

	// Advance the sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (in_fire) state_q <= ST_SCAN;
				ST_SCAN: if (sts.scan_done) state_q <= ST_OPS;
				ST_OPS:  if (sts.op_done) state_q <= ST_OUT;
				ST_OUT:  if (out_taken) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.start = in_fire;
		cmd.scan_step = (state_q == ST_SCAN);
		cmd.op_step = (state_q == ST_OPS);
	end
	assign busy = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
endmodule

FILE: sv/slru_dp.sv
`include "assert_macros.svh"
// Entry store, recency lists and totals; one scan slot or one list step per cycle
module slru_dp #(
	parameter int ENTRIES = 64,
	parameter int IW = $clog2(ENTRIES)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  slru_pkg::ctl_cmd_t cmd,
	output slru_pkg::ctl_sts_t sts,
	input  logic               in_cmd,
	input  logic [63:0]        in_key,
	input  logic [63:0]        in_value,
	input  logic [31:0]        in_size,
	input  logic [31:0]        demote_lim,
	input  logic [31:0]        evict_lim,
	output logic               hit,
	output logic [63:0]        read_value,
	output logic               evicted_valid,
	output logic [63:0]        evicted_key,
	output logic [63:0]        evicted_value,
	output logic               status
);
	localparam logic [IW:0] NIL = (IW+1)'(ENTRIES);

	// List step codes
	localparam logic [3:0] OP_RD     = 4'd0;
	localparam logic [3:0] OP_DECIDE = 4'd1;
	localparam logic [3:0] OP_UNL    = 4'd2;
	localparam logic [3:0] OP_DROP   = 4'd3;
	localparam logic [3:0] OP_FREE   = 4'd4;
	localparam logic [3:0] OP_WRITE  = 4'd5;
	localparam logic [3:0] OP_PUSH   = 4'd6;
	localparam logic [3:0] OP_CHKS   = 4'd7;
	localparam logic [3:0] OP_DEMRD  = 4'd8;
	localparam logic [3:0] OP_DEMPUSH= 4'd9;
	localparam logic [3:0] OP_CHKH   = 4'd10;
	localparam logic [3:0] OP_EVRD   = 4'd11;
	localparam logic [3:0] OP_DONE   = 4'd12;

	// Next step after an unlink
	localparam logic [1:0] AU_DROP  = 2'd0;
	localparam logic [1:0] AU_PUSHP = 2'd1;
	localparam logic [1:0] AU_DEM   = 2'd2;
	localparam logic [1:0] AU_EVICT = 2'd3;

	// Entry memories
	logic [63:0] key_mem   [ENTRIES];
	logic [63:0] val_mem   [ENTRIES];
	logic [31:0] size_mem  [ENTRIES];
	logic [IW:0] prev_mem  [ENTRIES];
	logic [IW:0] next_mem  [ENTRIES];
	logic [ENTRIES-1:0] valid_q, prot_q;
	logic [IW:0] ph_q, pt_q, bh_q, bt_q;
	logic [63:0] ptot_q, btot_q;

	logic        op_q;
	logic [63:0] key_q, val_q;
	logic [31:0] size_q;
	logic [IW:0] scan_q;
	logic [IW:0] found_q;
	logic [IW:0] free_q;
	logic [3:0]  step_q;
	logic [1:0]  after_q;
	logic [IW:0] tgt_q;
	logic [IW:0] p_q, n_q;
	logic [31:0] tsize_q;
	logic [63:0] tkey_q, tval_q;
	logic        tprot_q;

	// Registered scan read, compared in the cycle after the slot is read
	logic [63:0] scan_key_s1;
	logic        scan_live_s1;
	logic        scan_pend_s1;
	logic [IW:0] scan_at_s1;

	logic [IW-1:0] scan_idx, tgt_idx;
	assign scan_idx = scan_q[IW-1:0];
	assign tgt_idx = tgt_q[IW-1:0];
	logic [IW-1:0] free_idx;
	logic          free_any;

	// Lowest free slot
	always_comb begin
		free_idx = '0;
		free_any = 1'b0;
		for (int k = ENTRIES-1; k >= 0; k--) begin
			if (!valid_q[k]) begin
				free_idx = IW'(k);
				free_any = 1'b1;
			end
		end
	end

	logic hit_now;
	assign hit_now = scan_pend_s1 && scan_live_s1 && (scan_key_s1 == key_q);
	assign sts.scan_done = cmd.scan_step && scan_pend_s1 &&
		(hit_now || scan_at_s1 == NIL - (IW+1)'(1));
	assign sts.op_done = cmd.op_step && (step_q == OP_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			prot_q <= '0;
			ph_q <= NIL; pt_q <= NIL; bh_q <= NIL; bt_q <= NIL;
			ptot_q <= '0; btot_q <= '0;
			step_q <= OP_RD;
			scan_q <= '0;
			scan_pend_s1 <= 1'b0;
		end else if (cmd.start) begin
			op_q <= in_cmd; key_q <= in_key; val_q <= in_value; size_q <= in_size;
			scan_q <= '0; found_q <= NIL; step_q <= OP_RD;
			scan_pend_s1 <= 1'b0;
			hit <= 1'b0; read_value <= '0; evicted_valid <= 1'b0;
			evicted_key <= '0; evicted_value <= '0; status <= 1'b0;
		end else if (cmd.scan_step) begin
			// Walk the table one slot a cycle, compare the slot read last cycle
			if (hit_now) found_q <= scan_at_s1;
			if (scan_q != NIL) begin
				scan_key_s1 <= key_mem[scan_idx];
				scan_live_s1 <= valid_q[scan_idx];
				scan_at_s1 <= scan_q;
				scan_pend_s1 <= 1'b1;
				scan_q <= scan_q + (IW+1)'(1);
			end
		end else if (cmd.op_step) begin
			case (step_q)
				OP_RD: begin
					tgt_q <= found_q;
					if (found_q != NIL) begin
						tprot_q <= prot_q[found_q[IW-1:0]];
						p_q <= prev_mem[found_q[IW-1:0]];
						n_q <= next_mem[found_q[IW-1:0]];
						tsize_q <= size_mem[found_q[IW-1:0]];
						tkey_q <= key_mem[found_q[IW-1:0]];
						tval_q <= val_mem[found_q[IW-1:0]];
					end
					step_q <= OP_DECIDE;
				end
				OP_DECIDE: begin
					if (op_q == slru_pkg::CMD_PUT) begin
						after_q <= AU_DROP;
						step_q <= (tgt_q != NIL) ? OP_UNL : OP_FREE;
					end else if (tgt_q == NIL) begin
						step_q <= OP_DONE;
					end else begin
						hit <= 1'b1; read_value <= tval_q;
						key_q <= tkey_q; val_q <= tval_q; size_q <= tsize_q;
						after_q <= tprot_q ? AU_PUSHP : AU_DROP;
						step_q <= OP_UNL;
					end
				end
				OP_UNL: begin
					// Remove target from its list
					if (p_q != NIL) next_mem[p_q[IW-1:0]] <= n_q;
					if (n_q != NIL) prev_mem[n_q[IW-1:0]] <= p_q;
					if (tprot_q) begin
						ph_q <= (p_q == NIL) ? n_q : ph_q;
						pt_q <= (n_q == NIL) ? p_q : pt_q;
					end else begin
						bh_q <= (p_q == NIL) ? n_q : bh_q;
						bt_q <= (n_q == NIL) ? p_q : bt_q;
					end
					case (after_q)
						AU_DROP: step_q <= OP_DROP;
						AU_PUSHP: begin
							free_q <= tgt_q;
							step_q <= OP_PUSH;
						end
						AU_DEM: begin
							ptot_q <= ptot_q - 64'(tsize_q);
							step_q <= OP_DEMPUSH;
						end
						default: begin
							btot_q <= btot_q - 64'(tsize_q);
							valid_q[tgt_idx] <= 1'b0;
							step_q <= OP_DONE;
						end
					endcase
				end
				OP_DROP: begin
					if (tprot_q) ptot_q <= ptot_q - 64'(tsize_q);
					else btot_q <= btot_q - 64'(tsize_q);
					valid_q[tgt_idx] <= 1'b0;
					step_q <= OP_FREE;
				end
				OP_FREE: begin
					if (!free_any) begin
						status <= 1'b1;
						step_q <= OP_DONE;
					end else begin
						free_q <= {1'b0, free_idx};
						step_q <= OP_WRITE;
					end
				end
				OP_WRITE: begin
					key_mem[free_q[IW-1:0]] <= key_q;
					val_mem[free_q[IW-1:0]] <= val_q;
					size_mem[free_q[IW-1:0]] <= size_q;
					valid_q[free_q[IW-1:0]] <= 1'b1;
					ptot_q <= ptot_q + 64'(size_q);
					tprot_q <= 1'b1;
					step_q <= OP_PUSH;
				end
				OP_PUSH: begin
					// Place at the protected head
					prev_mem[free_q[IW-1:0]] <= NIL;
					next_mem[free_q[IW-1:0]] <= ph_q;
					if (ph_q != NIL) prev_mem[ph_q[IW-1:0]] <= free_q;
					else pt_q <= free_q;
					ph_q <= free_q;
					prot_q[free_q[IW-1:0]] <= 1'b1;
					step_q <= (after_q == AU_PUSHP) ? OP_DONE : OP_CHKS;
				end
				OP_CHKS: begin
					step_q <= (ptot_q > 64'(demote_lim) && pt_q != NIL) ? OP_DEMRD
						: OP_DONE;
				end
				OP_DEMRD, OP_EVRD: begin
					logic [IW:0] t;
					t = (step_q == OP_DEMRD) ? pt_q : bt_q;
					tgt_q <= t;
					tprot_q <= (step_q == OP_DEMRD);
					p_q <= prev_mem[t[IW-1:0]];
					n_q <= next_mem[t[IW-1:0]];
					tsize_q <= size_mem[t[IW-1:0]];
					if (step_q == OP_EVRD) begin
						evicted_valid <= 1'b1;
						evicted_key <= key_mem[t[IW-1:0]];
						evicted_value <= val_mem[t[IW-1:0]];
					end
					after_q <= (step_q == OP_DEMRD) ? AU_DEM : AU_EVICT;
					step_q <= OP_UNL;
				end
				OP_DEMPUSH: begin
					// Place demoted entry at the probation head
					prev_mem[tgt_idx] <= NIL;
					next_mem[tgt_idx] <= bh_q;
					if (bh_q != NIL) prev_mem[bh_q[IW-1:0]] <= tgt_q;
					else bt_q <= tgt_q;
					bh_q <= tgt_q;
					prot_q[tgt_idx] <= 1'b0;
					btot_q <= btot_q + 64'(tsize_q);
					step_q <= OP_CHKH;
				end
				OP_CHKH: begin
					step_q <= (ptot_q + btot_q > 64'(evict_lim) && bt_q != NIL) ?
						OP_EVRD : OP_DONE;
				end
				default: step_q <= OP_DONE;
			endcase
		end
	end

	`ASSERT_IMPL(a_evict_has_put, clk, arst_n, sts.op_done && evicted_valid, !status)
	`ASSERT_IMPL(a_reject_put, clk, arst_n, sts.op_done && status, op_q == slru_pkg::CMD_PUT)
	`ASSERT_NEXT(a_scan_stop, clk, arst_n, sts.scan_done, !cmd.scan_step || cmd.start)
endmodule

FILE: sv/segmented_lru_size_cache_unit.sv
// Each accepted word yields one result word; its key scan and list steps run in between.
// The key scan runs first (one slot a cycle, registered read),
// then up to 15 list steps; a get miss needs 3 steps, a plain put 7.
// One word at a time; the next is accepted in the cycle after the result is taken.
// Reset (arst_n low): lists empty, totals zero, limits 1024 and 2048.
// Valid bits clear at once; no clearing pass is needed.
module segmented_lru_size_cache_unit #(
	parameter int ENTRIES = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [159:0] s_tdata,  // key[63:0], value[127:64], item_size[159:128]
	input  logic         s_tuser,  // cmd
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [191:0] m_tdata,  // read_value, evicted_key, evicted_value
	output logic [2:0]   m_tuser,  // hit, evicted_valid, status
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [0:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	slru_pkg::ctl_cmd_t cmd;
	slru_pkg::ctl_sts_t sts;
	logic busy, hit, ev, status;
	logic [63:0] rv, ek, evv;
	logic [31:0] soft_q, hard_q;

	assign s_tready = !busy;
	assign cfg_ready = 1'b1;

	// Hold limits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			soft_q <= 32'd1024;
			hard_q <= 32'd2048;
		end else if (cfg_valid) begin
			if (cfg_index == slru_pkg::REG_SOFT) soft_q <= cfg_data;
			else hard_q <= cfg_data;
		end
	end

	slru_ctrl u_ctrl (
		.clk, .arst_n, .in_fire(s_tvalid && s_tready), .sts,
		.out_taken(m_tvalid && m_tready), .cmd, .busy, .out_valid(m_tvalid)
	);

	slru_dp #(.ENTRIES(ENTRIES)) u_dp (
		.clk, .arst_n, .cmd, .sts,
		.in_cmd(s_tuser), .in_key(s_tdata[63:0]), .in_value(s_tdata[127:64]),
		.in_size(s_tdata[159:128]), .demote_lim(soft_q), .evict_lim(hard_q),
		.hit, .read_value(rv), .evicted_valid(ev), .evicted_key(ek),
		.evicted_value(evv), .status
	);

	assign m_tdata = {evv, ek, rv};
	assign m_tuser = {status, ev, hit};
endmodule
